FILE: design/bgd_pkg.sv
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types, codes and constants of the button gesture detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bgd_pkg;

  localparam int AGE_W     = 17;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  localparam logic             RST_ACTIVE_HIGH  = 1'b1;
  localparam logic [CFG_W-1:0] RST_DEBOUNCE     = 16'd30;
  localparam logic [CFG_W-1:0] RST_DOUBLE_CLICK = 16'd350;
  localparam logic [CFG_W-1:0] RST_LONG_PRESS   = 16'd800;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_HIGH  = 2'd0,
    CFG_DEBOUNCE     = 2'd1,
    CFG_DOUBLE_CLICK = 2'd2,
    CFG_LONG_PRESS   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    G_NONE       = 3'd0,
    G_LONG_START = 3'd1,
    G_LONG_END   = 3'd2,
    G_DOUBLE     = 3'd3,
    G_SINGLE     = 3'd4
  } gesture_t;

  typedef struct packed {
    logic             active_high;
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] double_click_ticks;
    logic [CFG_W-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    gesture_t gesture;
    logic     pressed_now;
  } result_t;

  // saturating tick counter
  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
    age_inc = (a == AGE_MAX) ? AGE_MAX : a + 1'b1;
  endfunction

endpackage

`default_nettype wire

FILE: design/bgd_in_if.sv
// ----------------------------------------------------------------------------
// bgd_in_if
// Sample channel: one raw pin level per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgd_in_if;
  logic valid;
  logic ready;
  logic raw_level;

  modport source (output valid, output raw_level, input ready);
  modport sink   (input valid, input raw_level, output ready);
endinterface

`default_nettype wire

FILE: design/bgd_out_if.sv
// ----------------------------------------------------------------------------
// bgd_out_if
// Result channel: gesture code and debounced pressed state per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] gesture;
  logic       pressed_now;

  modport source (output valid, output gesture, output pressed_now, input ready);
  modport sink   (input valid, input gesture, input pressed_now, output ready);
endinterface

`default_nettype wire

FILE: design/bgd_cfg_regs.sv
// ----------------------------------------------------------------------------
// bgd_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
`default_nettype none

module bgd_cfg_regs
  import bgd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output cfg_t                      cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ACTIVE_HIGH:  cfg_nxt.active_high        = cfg_data[0];
        CFG_DEBOUNCE:     cfg_nxt.debounce_ticks     = cfg_data;
        CFG_DOUBLE_CLICK: cfg_nxt.double_click_ticks = cfg_data;
        CFG_LONG_PRESS:   cfg_nxt.long_press_ticks   = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_high        <= RST_ACTIVE_HIGH;
      cfg_r.debounce_ticks     <= RST_DEBOUNCE;
      cfg_r.double_click_ticks <= RST_DOUBLE_CLICK;
      cfg_r.long_press_ticks   <= RST_LONG_PRESS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: design/bgd_step.sv
// ----------------------------------------------------------------------------
// bgd_step
// Debounce and gesture state; computes one tick per accepted word.
// ----------------------------------------------------------------------------
`default_nettype none

module bgd_step
  import bgd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic raw_level,
  input  wire cfg_t cfg,
  output result_t   result
);

  logic             prev_raw_r,      prev_raw_nxt;
  logic [AGE_W-1:0] bounce_age_r,    bounce_age_nxt;
  logic             debounced_r,     debounced_nxt;
  logic             deb_before_r;
  logic [AGE_W-1:0] hold_age_r,      hold_age_nxt;
  logic             long_active_r,   long_active_nxt;
  logic             click_pending_r, click_pending_nxt;
  logic [AGE_W-1:0] release_age_r,   release_age_nxt;

  logic     raw_pressed;
  logic     press_edge;
  logic     release_edge;
  gesture_t gesture;

  always_comb begin
    raw_pressed = cfg.active_high ? raw_level : ~raw_level;
    gesture     = G_NONE;

    // debounce
    bounce_age_nxt = (raw_level != prev_raw_r) ? '0 : age_inc(bounce_age_r);
    debounced_nxt  = (bounce_age_nxt > {1'b0, cfg.debounce_ticks}) ? raw_pressed
                                                                    : debounced_r;
    prev_raw_nxt   = raw_level;

    press_edge   = debounced_nxt & ~deb_before_r;
    release_edge = ~debounced_nxt & deb_before_r;

    hold_age_nxt      = press_edge ? '0 : age_inc(hold_age_r);
    long_active_nxt   = press_edge ? 1'b0 : long_active_r;
    click_pending_nxt = click_pending_r;
    release_age_nxt   = age_inc(release_age_r);

    if (debounced_nxt && !long_active_nxt &&
        hold_age_nxt >= {1'b0, cfg.long_press_ticks}) begin
      long_active_nxt   = 1'b1;
      click_pending_nxt = 1'b0;
      gesture           = G_LONG_START;
    end

    if (release_edge) begin
      if (long_active_nxt) begin
        long_active_nxt = 1'b0;
        gesture         = G_LONG_END;
      end else if (click_pending_nxt &&
                   release_age_nxt <= {1'b0, cfg.double_click_ticks}) begin
        click_pending_nxt = 1'b0;
        gesture           = G_DOUBLE;
      end else begin
        // first release, or second one too late: open a new window
        click_pending_nxt = 1'b1;
        release_age_nxt   = '0;
      end
    end

    if (click_pending_nxt && release_age_nxt > {1'b0, cfg.double_click_ticks}) begin
      click_pending_nxt = 1'b0;
      gesture           = G_SINGLE;
    end

    result.gesture     = gesture;
    result.pressed_now = debounced_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r      <= 1'b1;
      bounce_age_r    <= '0;
      debounced_r     <= 1'b0;
      deb_before_r    <= 1'b0;
      hold_age_r      <= '0;
      long_active_r   <= 1'b0;
      click_pending_r <= 1'b0;
      release_age_r   <= '0;
    end else if (in_fire) begin
      prev_raw_r      <= prev_raw_nxt;
      bounce_age_r    <= bounce_age_nxt;
      debounced_r     <= debounced_nxt;
      deb_before_r    <= debounced_nxt;
      hold_age_r      <= hold_age_nxt;
      long_active_r   <= long_active_nxt;
      click_pending_r <= click_pending_nxt;
      release_age_r   <= release_age_nxt;
    end
  end

  // a long press cancels any pending click and never outlives the press
  a_long_no_click: assert property (@(posedge clk) disable iff (!rst_n)
    !(long_active_r && click_pending_r))
    else $error("long press and pending click both set");

  a_long_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    long_active_r |-> debounced_r)
    else $error("long press active while released");

  a_before_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_fire) |-> deb_before_r == debounced_r)
    else $error("edge history out of step with debounced level");

endmodule

`default_nettype wire

FILE: design/bgd_top.sv
// ----------------------------------------------------------------------------
// button_gesture_detector_top
// Debounced button with long press, double click and single click detection.
// ----------------------------------------------------------------------------
// Each input word is one raw pin sample taken on a 1 ms tick; each yields
// exactly one result word in the next cycle (gesture code, debounced state).
// The block takes one sample per clock: the tick logic sits between the state
// registers and a single result register, and in_ch.ready is high whenever
// that register is empty or being read. The user writes configuration via
// cfg_we/cfg_index/cfg_data while no word is in flight; it is not enforced.
`default_nettype none

module button_gesture_detector_top
  import bgd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  bgd_in_if.sink                    in_ch,
  bgd_out_if.source                 out_ch
);

  cfg_t    cfg;
  result_t result;
  result_t result_r;
  logic    out_valid_r, out_valid_nxt;
  logic    in_ready;
  logic    in_fire;

  assign in_ready = ~out_valid_r | out_ch.ready;
  assign in_fire  = in_ch.valid & in_ready;

  bgd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bgd_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .raw_level (in_ch.raw_level),
    .cfg       (cfg),
    .result    (result)
  );

  assign out_valid_nxt = in_fire | (out_valid_r & ~out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result;
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.gesture     = result_r.gesture;
  assign out_ch.pressed_now = result_r.pressed_now;

  a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted word produced no result");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !in_fire)
    else $error("accepted word while result held");

endmodule

`default_nettype wire
